@@ rtl/core/wmsa_pkg.sv @@
// Shared widths, reset values and register codes of the windowed mean-square activity detector.
package wmsa_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SQ_W           = 31;
    localparam int THR_W          = 31;
    localparam int WINDOW_LEN_DEF = 20;
    localparam int CFG_IDX_W      = 1;
    // The window sum is divided in two halves; this is the width of the low half.
    localparam int LO_W           = 18;

    localparam logic [THR_W-1:0] THRESH_RST = THR_W'(5000);
    localparam logic             POL_RST    = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_POLARITY  = 1'b1
    } cfg_reg_t;

endpackage

@@ rtl/core/wmsa_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
module wmsa_ram
#(
    parameter int WIDTH = 31,
    parameter int DEPTH = 20
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/wmsa_div.sv @@
// Pipelined division of the window sum by the window length, by reciprocal multiplication.
module wmsa_div
    import wmsa_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [SQ_W+$clog2(WINDOW_LEN)-1:0]    in_sum,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [SQ_W-1:0]                       out_mean
);

    localparam int SumW = SQ_W + $clog2(WINDOW_LEN);
    localparam int HiW  = SumW - LO_W;
    localparam int RemW = $clog2(WINDOW_LEN);
    // Both partial dividends stay below 2**DivW, so the reciprocal is off by at most one.
    localparam int DivW = LO_W + RemW;
    localparam logic [63:0] RecipFull = (64'd1 << DivW) / 64'(WINDOW_LEN);
    localparam logic [DivW-1:0] Recip = RecipFull[DivW-1:0];
    localparam logic [DivW-1:0] Divisor = DivW'(WINDOW_LEN);

    // Stage valid bits: b, c, d, e and the output register o.
    logic b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, o_valid_reg;
    logic b_valid_next, c_valid_next, d_valid_next, e_valid_next, o_valid_next;
    logic b_adv, c_adv, d_adv, e_adv, o_adv, b_load;

    logic [SumW-1:0]   b_sum_reg;
    logic [2*DivW-1:0] c_prod_reg;
    logic [HiW-1:0]    c_hi_reg;
    logic [LO_W-1:0]   c_lo_reg;
    logic [HiW-1:0]    d_qh_reg;
    logic [RemW-1:0]   d_rh_reg;
    logic [LO_W-1:0]   d_lo_reg;
    logic [2*DivW-1:0] e_prod_reg;
    logic [DivW-1:0]   e_x_reg;
    logic [HiW-1:0]    e_qh_reg;
    logic [SQ_W-1:0]   o_mean_reg;

    logic [2*DivW-1:0] b_prod;
    logic [DivW-1:0]   c_q0, c_r0, c_q, c_r;
    logic [DivW-1:0]   d_x;
    logic [2*DivW-1:0] d_prod;
    logic [DivW-1:0]   e_q0, e_r0, e_q;
    logic [SumW-1:0]   e_mean_full;

    // A stage moves on when the one after it is empty or moving on too.
    assign o_adv    = o_valid_reg && !out_stall;
    assign e_adv    = e_valid_reg && (!o_valid_reg || o_adv);
    assign d_adv    = d_valid_reg && (!e_valid_reg || e_adv);
    assign c_adv    = c_valid_reg && (!d_valid_reg || d_adv);
    assign b_adv    = b_valid_reg && (!c_valid_reg || c_adv);
    assign in_stall = b_valid_reg && !b_adv;
    assign b_load   = in_valid && !in_stall;

    always_comb
    begin
        b_valid_next = b_load ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
        c_valid_next = b_adv  ? 1'b1 : (c_adv ? 1'b0 : c_valid_reg);
        d_valid_next = c_adv  ? 1'b1 : (d_adv ? 1'b0 : d_valid_reg);
        e_valid_next = d_adv  ? 1'b1 : (e_adv ? 1'b0 : e_valid_reg);
        o_valid_next = e_adv  ? 1'b1 : (o_adv ? 1'b0 : o_valid_reg);
    end

    // Upper half: quotient and remainder of sum / N.
    assign b_prod = DivW'(b_sum_reg[SumW-1:LO_W]) * Recip;

    always_comb
    begin
        c_q0 = c_prod_reg[2*DivW-1:DivW];
        c_r0 = DivW'(c_hi_reg) - DivW'(c_q0 * Divisor);
        if (c_r0 >= Divisor)
        begin
            c_q = c_q0 + 1'b1;
            c_r = c_r0 - Divisor;
        end
        else
        begin
            c_q = c_q0;
            c_r = c_r0;
        end
    end

    // Lower half: the upper remainder joined with the low bits, again divided by N.
    assign d_x    = {d_rh_reg, d_lo_reg};
    assign d_prod = d_x * Recip;

    always_comb
    begin
        e_q0 = e_prod_reg[2*DivW-1:DivW];
        e_r0 = e_x_reg - DivW'(e_q0 * Divisor);
        e_q  = (e_r0 >= Divisor) ? e_q0 + 1'b1 : e_q0;
        e_mean_full = {e_qh_reg, e_q[LO_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            e_valid_reg <= e_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_sum_reg <= in_sum;
        end
        if (b_adv)
        begin
            c_prod_reg <= b_prod;
            c_hi_reg   <= b_sum_reg[SumW-1:LO_W];
            c_lo_reg   <= b_sum_reg[LO_W-1:0];
        end
        if (c_adv)
        begin
            d_qh_reg <= c_q[HiW-1:0];
            d_rh_reg <= c_r[RemW-1:0];
            d_lo_reg <= c_lo_reg;
        end
        if (d_adv)
        begin
            e_prod_reg <= d_prod;
            e_x_reg    <= d_x;
            e_qh_reg   <= d_qh_reg;
        end
        if (e_adv)
        begin
            o_mean_reg <= e_mean_full[SQ_W-1:0];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_mean  = o_mean_reg;

endmodule

@@ rtl/core/windowed_mean_square_activity_top.sv @@
// Windowed mean-square activity detector: top level with ring memory, running sum and config.
//
// Each accepted sample is squared and written into a ring of WINDOW_LEN squares held in one
// synchronous RAM; the square it replaces is read in the cycle of acceptance and taken out of a
// running sum when the sample leaves stage a, together with the write back. The block takes one
// sample per clock cycle sustained while the result channel does not stall; the single read and
// write of the ring memory and the running-sum update, done once per sample, set that figure.
// The first WINDOW_LEN-1 samples give no result; from then on every sample gives one, passing
// through stage a (the square, the ring read and the running-sum update), the division of the
// sum by WINDOW_LEN (reciprocal multiplication in two halves) in stages b, c, d and e, and the
// output register o. A fill count tracks which ring entries hold data, so no clearing pass runs
// after reset. The activity flag is formed from the registered mean and the current threshold
// and polarity; the configuration channel is always ready and takes one register write per cycle.
module windowed_mean_square_activity_top
    import wmsa_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic signed [15:0]   sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [30:0]          mean_square,
    output logic                 active,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    localparam int SlotW = $clog2(WINDOW_LEN);
    localparam int CntW  = $clog2(WINDOW_LEN + 1);
    localparam int SumW  = SQ_W + $clog2(WINDOW_LEN);
    localparam int MagW  = SAMPLE_W + 1;

    logic [THR_W-1:0] thr_reg, thr_next;
    logic             pol_reg, pol_next;
    logic [SlotW-1:0] slot_reg, slot_next;
    logic [CntW-1:0]  fill_reg, fill_next;
    logic [SumW-1:0]  sum_reg, sum_next, sum_upd;

    // Stage a: the accepted sample's square, its ring slot and what the window holds.
    logic             a_valid_reg, a_valid_next;
    logic [SQ_W-1:0]  a_sq_reg;
    logic [SlotW-1:0] a_slot_reg;
    logic             a_full_reg;
    logic             a_result_reg;

    logic             accept, a_adv;
    logic             div_stall;
    logic [SQ_W-1:0]  old_sq;
    logic [SumW-1:0]  old_term;
    logic signed [MagW-1:0] sample_ext;
    logic [MagW-1:0]        mag;
    logic [2*MagW-1:0]      sq_full;
    logic                   below;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        pol_next = pol_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: thr_next = cfg_data;
                REG_POLARITY:  pol_next = cfg_data[0];
            endcase
        end
    end

    // Squaring of the magnitude; the most negative sample squares to exactly 2**30.
    always_comb
    begin
        sample_ext = MagW'(sample);
        mag        = sample_ext[MagW-1] ? MagW'(-sample_ext) : MagW'(sample_ext);
        sq_full    = mag * mag;
    end

    // Samples that give no result leave stage a without waiting for the divider.
    assign a_adv        = a_valid_reg && (!a_result_reg || !div_stall);
    assign sample_stall = a_valid_reg && !a_adv;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        a_valid_next = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        if (accept)
        begin
            slot_next = (slot_reg == SlotW'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
            if (fill_reg != CntW'(WINDOW_LEN))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        old_term = a_full_reg ? SumW'(old_sq) : '0;
        sum_upd  = sum_reg - old_term + SumW'(a_sq_reg);
        sum_next = a_adv ? sum_upd : sum_reg;
    end

    // The entry read at acceptance was written at least two transactions earlier, and the
    // read data holds while stage a waits, so no forwarding is needed.
    wmsa_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk     (clk),
        .wr_en   (a_adv),
        .wr_addr (a_slot_reg),
        .wr_data (a_sq_reg),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (old_sq)
    );

    wmsa_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg && a_result_reg),
        .in_stall  (div_stall),
        .in_sum    (sum_upd),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_mean  (mean_square)
    );

    assign below  = SQ_W'(mean_square) < thr_reg;
    assign active = pol_reg ? !below : below;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESH_RST;
            pol_reg     <= POL_RST;
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg     <= thr_next;
            pol_reg     <= pol_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sq_reg     <= sq_full[SQ_W-1:0];
            a_slot_reg   <= slot_reg;
            a_full_reg   <= (fill_reg == CntW'(WINDOW_LEN));
            a_result_reg <= (fill_reg >= CntW'(WINDOW_LEN - 1));
        end
    end

`ifndef ASSERT_OFF
    // The ring write of one sample never lands on the slot read for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && a_adv) |-> (a_slot_reg != slot_reg))
        else $error("ring read and write address collide");

    // The fill count only grows, one per transaction, until the window is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (fill_reg != CntW'(WINDOW_LEN))) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance");

    // A waiting sample keeps its slot, so the held read data stays matched to it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |=> (a_valid_reg && $stable(a_slot_reg)))
        else $error("stage a changed while stalled");

    // No result may reach the divider before the window is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_result_reg) |-> (fill_reg == CntW'(WINDOW_LEN)))
        else $error("result before the window is full");
`endif

endmodule

@@ tb/sv/tb_windowed_mean_square_activity_top.sv @@
// Self-checking testbench for the windowed mean-square activity detector top level.
`timescale 1ns / 100ps

module tb_windowed_mean_square_activity_top
    import wmsa_pkg::*;
();

    localparam int WINDOW        = WINDOW_LEN_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 250;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [SQ_W-1:0] mean_square;
        logic            active;
    } window_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    logic signed [15:0]   sample;
    logic                 result_valid;
    logic                 result_stall;
    logic [30:0]          mean_square;
    logic                 active;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;

    // Predictor state: the ring of squares, its running sum and the register copies.
    logic [SQ_W-1:0]      ring_squares [WINDOW];
    logic [35:0]          window_total = '0;
    int                   ring_fill    = 0;
    int                   ring_slot    = 0;
    logic [THR_W-1:0]     model_threshold = THRESH_RST;
    logic                 model_polarity  = POL_RST;

    window_result_t       pending_means [$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    bit                   tx_idle_en     = 1'b0;
    bit                   rx_idle_en     = 1'b0;
    bit                   long_hold_req  = 1'b0;

    windowed_mean_square_activity_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mean_square  (mean_square),
        .active       (active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s", $time, msg);
    endtask

    // Updates the ring for one accepted sample and queues the result it causes, if any.
    task automatic predict_window(input logic signed [15:0] value);
        logic [15:0]     magnitude;
        logic [SQ_W-1:0] square;
        logic [35:0]     mean;
        logic            below;
        window_result_t  res;
        magnitude = value[15] ? 16'(-value) : 16'(value);
        square = SQ_W'({16'd0, magnitude} * {16'd0, magnitude});
        if (ring_fill == WINDOW)
            window_total -= ring_squares[ring_slot];
        else
            ring_fill++;
        ring_squares[ring_slot] = square;
        window_total += square;
        ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
        if (ring_fill == WINDOW)
        begin
            mean = window_total / 36'(WINDOW);
            below = mean < {5'd0, model_threshold};
            res.mean_square = mean[SQ_W-1:0];
            res.active = model_polarity ? !below : below;
            pending_means.push_back(res);
        end
    endtask

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_means.size() == 0)
                report_mismatch($sformatf("result with none pending: mean_square %0d active %0d",
                                          mean_square, active));
            else
            begin
                want = pending_means.pop_front();
                if (mean_square !== want.mean_square)
                    report_mismatch($sformatf("mean_square: expected %0d, got %0d",
                                              want.mean_square, mean_square));
                if (active !== want.active)
                    report_mismatch($sformatf("active: expected %0d, got %0d (mean %0d)",
                                              want.active, active, want.mean_square));
            end
        end
    end

    // Result side back-pressure: random short bursts, or one long hold on request.
    initial
    begin
        int n;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Valid stays high between back-to-back transactions; it only drops for a gap.
    task automatic send_sample(input logic signed [15:0] value);
        int n;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 9);
            sample_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_window(value);
    endtask

    // Waits until every expected result has arrived and the filling pipeline is empty.
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [THR_W-1:0] level, input logic polarity);
        cfg_reg_t idx;
        for (int k = 0; k < 2; k++)
        begin
            idx = (k == 0) ? REG_THRESHOLD : REG_POLARITY;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (idx == REG_THRESHOLD) ? level : {(THR_W-1)'($urandom), polarity};
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx == REG_THRESHOLD)
                model_threshold = level;
            else
                model_polarity = polarity;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_amplitude();
        case ($urandom_range(0, 3))
            0:       return 60;
            1:       return 300;
            2:       return 4000;
            default: return 32767;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample(input int unsigned amp);
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default:
            begin
                if (amp >= 32767)
                    return 16'($urandom);
                else
                    return 16'(int'($urandom_range(0, 2 * amp)) - int'(amp));
            end
        endcase
    endfunction

    // The window fills with the most negative sample, so the first result is the largest
    // mean; then a threshold above that mean must always flag under polarity 0.
    task automatic test_window_fill_extremes();
        logic signed [15:0] edge_values [5];
        edge_values = '{16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
        configure(31'h4000_0000, 1'b1);
        repeat (WINDOW) send_sample(16'h8000);
        settle();
        configure(31'h7FFF_FFFF, 1'b0);
        foreach (edge_values[i])
            send_sample(edge_values[i]);
    endtask

    task automatic test_random_windows();
        int unsigned      amp;
        int unsigned      base_amp;
        logic [THR_W-1:0] level;
        int               run;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int phase = 0; phase < 8; phase++)
        begin
            base_amp = pick_amplitude();
            case ($urandom_range(0, 4))
                0:       level = '0;
                1:       level = 31'h4000_0000;
                2:       level = 31'h7FFF_FFFF;
                default: level = THR_W'($urandom_range(0, base_amp * base_amp / 2));
            endcase
            settle();
            configure(level, 1'($urandom_range(0, 1)));
            run = 0;
            amp = base_amp;
            for (int n = 0; n < 110; n++)
            begin
                // The amplitude changes in runs so the window mean drifts across the threshold.
                if (run == 0)
                begin
                    run = $urandom_range(10, 40);
                    amp = pick_amplitude();
                end
                run--;
                send_sample(pick_sample(amp));
            end
        end
    endtask

    // The receiver holds off for a long stretch while samples keep coming, so the block
    // fills up and has to stall the sample channel.
    task automatic test_output_hold();
        settle();
        configure(THR_W'($urandom_range(0, 1 << 24)), 1'b0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        long_hold_req = 1'b1;
        repeat (100) send_sample(pick_sample(4000));
    endtask

    task automatic test_steady_stream();
        settle();
        configure(THRESH_RST, 1'b1);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (200) send_sample(pick_sample(pick_amplitude()));
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_THRESHOLD;
        cfg_data     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_fill_extremes();
        test_random_windows();
        test_output_hold();
        test_steady_stream();

        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/wmsa_pkg.sv
rtl/core/wmsa_ram.sv
rtl/core/wmsa_div.sv
rtl/core/windowed_mean_square_activity_top.sv
tb/sv/tb_windowed_mean_square_activity_top.sv
